// ===== hdl/upd_pkg.sv =====
// Package for the URL percent decoder: the command type passed from the front end
// to the output stage, plus character constants and hex digit helpers.
// No dependencies.
package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned MAX_OUT = 3;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [1:0]              cnt;
    logic                    last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= 8'h39) begin
      hex_val = b[3:0];
    end else begin
      hex_val = b[3:0] + 4'd9;
    end
  endfunction

endpackage

// ===== hdl/upd_front.sv =====
// Front end of the URL percent decoder: tracks the escape sequence state and turns each
// input item into a command of one to three output bytes, or none while an escape is open.
// Depends on upd_pkg.
module upd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output upd_pkg::cmd_t cmd,
  output logic          cmd_push
);
  import upd_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       dig;
  logic       pct;
  logic [7:0] decoded;

  assign dig     = is_hex(in_byte);
  assign pct     = (in_byte == PCT_CHAR);
  assign decoded = {hex_val(held_r), hex_val(in_byte)};

  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    cmd.data  = '0;
    cmd.cnt   = 2'd0;
    cmd.last  = in_last;
    unique case (phase_r)
      PH_PCT: begin
        if (dig) begin
          if (in_last) begin
            cmd.data[0] = PCT_CHAR;
            cmd.data[1] = in_byte;
            cmd.cnt     = 2'd2;
          end else begin
            phase_nxt = PH_DIG;
            held_nxt  = in_byte;
          end
        end else begin
          cmd.data[0] = PCT_CHAR;
          if (pct && !in_last) begin
            cmd.cnt   = 2'd1;
            phase_nxt = PH_PCT;
          end else begin
            cmd.data[1] = in_byte;
            cmd.cnt     = 2'd2;
          end
        end
      end
      PH_DIG: begin
        if (dig) begin
          cmd.data[0] = decoded;
          cmd.cnt     = 2'd1;
        end else begin
          cmd.data[0] = PCT_CHAR;
          cmd.data[1] = held_r;
          if (pct && !in_last) begin
            cmd.cnt   = 2'd2;
            phase_nxt = PH_PCT;
          end else begin
            cmd.data[2] = in_byte;
            cmd.cnt     = 2'd3;
          end
        end
      end
      default: begin
        if (pct && !in_last) begin
          phase_nxt = PH_PCT;
        end else begin
          cmd.data[0] = in_byte;
          cmd.cnt     = 2'd1;
        end
      end
    endcase
  end

  assign cmd_push = fire && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== hdl/upd_queue.sv =====
// Short command queue between the front end and the output stage of the decoder.
// Depends on upd_pkg.
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  upd_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output upd_pkg::cmd_t head,
  output logic          valid,
  output logic          q_full
);
  import upd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign valid  = (count_r != '0);
  assign q_full = (count_r == CW'(DEPTH));
  assign head   = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !q_full;
  assign do_rd  = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/upd_back.sv =====
// Output stage of the decoder: walks the bytes of the head command one per popped item.
// Depends on upd_pkg.
module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  upd_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          head_done,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          empty,
  input  logic          pop
);
  import upd_pkg::*;

  logic [1:0] idx_r;
  logic       at_end;
  logic       take;

  assign empty     = !head_valid;
  assign take      = pop && head_valid;
  assign at_end    = (idx_r == (head.cnt - 2'd1));
  assign out_byte  = head.data[idx_r];
  assign out_last  = head.last && at_end;
  assign head_done = take && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// ===== hdl/url_percent_decoder_unit.sv =====
// URL percent decoder top level: front end, command queue and output stage.
// Depends on upd_pkg, upd_front, upd_queue and upd_back.
//
// Input side is a queue write port: an item (in_byte, in_last) is taken at a
// clock edge where push is high and full is low. Output side is a queue read
// port: while empty is low, out_byte and out_last show the oldest decoded byte,
// and it is taken at an edge where pop is high.
// A '%' followed by two upper-case hex digits becomes one byte; a broken
// sequence is passed through unchanged. out_last marks the final byte of a
// string and follows an item with in_last set.
// A byte appears on the output once the command that holds it has been
// written into the queue and reached its head. Throughput: one item per
// cycle while full is low, since the front end handles each item as it is
// taken and the output stage drains one byte per cycle while pop is high. An
// item that expands to two or three bytes holds the output stage for one pop
// per byte, and the QUEUE_DEPTH entry queue absorbs this until full rises.
// When the receiver stalls, results wait in the queue and full rises once it
// holds QUEUE_DEPTH commands. Reset empties the queue and clears any pending
// escape sequence.
module url_percent_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       empty,
  input  logic       pop
);
  import upd_pkg::*;

  cmd_t cmd;
  cmd_t q_head;
  logic cmd_push;
  logic q_valid;
  logic q_full;
  logic head_done;
  logic fire;

  assign full = q_full;
  assign fire = push && !q_full;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .rd_en  (head_done),
    .head   (q_head),
    .valid  (q_valid),
    .q_full (q_full)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .head_done  (head_done),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .empty      (empty),
    .pop        (pop)
  );

  // A command is never written while the queue has no room.
  assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !q_full)
    else $error("command written into a full queue");

  // A written command makes the queue non-empty on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) cmd_push |=> q_valid)
    else $error("queue empty after a command was written");

  // Every queued command carries at least one byte.
  assert property (@(posedge clk) disable iff (!rst_n) q_valid |-> (q_head.cnt != 2'd0))
    else $error("queued command holds no bytes");

endmodule

// ===== sim/tb_url_percent_decoder_unit.sv =====
// Self-checking testbench for url_percent_decoder_unit: a directed table, then random
// escape sequences, with random idling and one long receiver hold-off.
// Depends on upd_pkg and the url_percent_decoder_unit RTL.
`timescale 1ns / 100ps

module tb_url_percent_decoder_unit;
  import upd_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } dec_byte_t;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
    logic       efin;
  } dir_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 155;
  localparam int CALM_FROM    = 125;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 80;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{"A",      1'b0, 1'b1, 2'd1, "A",      8'h00, 8'h00,    1'b0},
    '{8'hFF,    1'b1, 1'b1, 2'd1, 8'hFF,    8'h00, 8'h00,    1'b1},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"4",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"1",      1'b0, 1'b1, 2'd1, "A",      8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"F",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"F",      1'b1, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"a",      1'b0, 1'b1, 2'd2, PCT_CHAR, "a",   8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"4",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"g",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"4",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"1",      1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b1, 1'b1, 2'd1, PCT_CHAR, 8'h00, 8'h00,    1'b1},
    '{PCT_CHAR, 1'b0, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"3",      1'b1, 1'b0, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{"3",      1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{PCT_CHAR, 1'b1, 1'b1, 2'd3, PCT_CHAR, "3",   PCT_CHAR, 1'b1},
    '{PCT_CHAR, 1'b0, 1'b1, 2'd0, 8'h00,    8'h00, 8'h00,    1'b0},
    '{8'h00,    1'b0, 1'b1, 2'd2, PCT_CHAR, 8'h00, 8'h00,    1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic [7:0] in_byte;
  logic       in_last;
  logic       push;
  logic       full;
  logic [7:0] out_byte;
  logic       out_last;
  logic       empty;
  logic       pop;

  esc_state_t esc_state;
  logic [7:0] first_digit;
  dec_byte_t  step_bytes[$];
  dec_byte_t  expected_bytes[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         long_hold_req = 1'b0;

  url_percent_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .push     (push),
    .full     (full),
    .out_byte (out_byte),
    .out_last (out_last),
    .empty    (empty),
    .pop      (pop)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_upper_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    return (c <= 8'h39) ? 4'(c - 8'h30) : 4'(c - 8'h41 + 8'd10);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v);
    return (v < 10) ? 8'(8'h30 + v) : 8'(8'h41 + v - 10);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) != 0) begin
      return 0;
    end
    return $urandom_range(1, 15);
  endfunction

  task automatic emit(input logic [7:0] c);
    step_bytes.push_back('{data: c, fin: 1'b0});
  endtask

  // Advances the decoder state by one input item and leaves its output bytes in step_bytes.
  task automatic decode_byte(input logic [7:0] c, input logic fin);
    bit reprocess;
    reprocess = 1'b0;
    step_bytes.delete();
    case (esc_state)
      ESC_PCT: begin
        if (is_upper_hex(c)) begin
          first_digit = c;
          esc_state = ESC_DIGIT;
        end else begin
          emit(PCT_CHAR);
          esc_state = ESC_NONE;
          reprocess = 1'b1;
        end
      end
      ESC_DIGIT: begin
        if (is_upper_hex(c) && is_upper_hex(first_digit)) begin
          emit({nibble_of(first_digit), nibble_of(c)});
        end else begin
          emit(PCT_CHAR);
          emit(first_digit);
          reprocess = 1'b1;
        end
        esc_state = ESC_NONE;
        first_digit = 8'h00;
      end
      default: begin
        esc_state = ESC_NONE;
        reprocess = 1'b1;
      end
    endcase
    if (reprocess) begin
      if (c == PCT_CHAR) begin
        esc_state = ESC_PCT;
      end else begin
        emit(c);
      end
    end
    if (fin) begin
      if (esc_state == ESC_PCT) begin
        emit(PCT_CHAR);
      end else if (esc_state == ESC_DIGIT) begin
        emit(PCT_CHAR);
        emit(first_digit);
      end
      esc_state = ESC_NONE;
      first_digit = 8'h00;
      if (step_bytes.size() > 0) begin
        step_bytes[step_bytes.size() - 1].fin = 1'b1;
      end
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic fin, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      in_byte <= 8'($urandom);
      in_last <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= c;
    in_last <= fin;
    do @(posedge clk); while (full);
  endtask

  task automatic queue_step_bytes();
    foreach (step_bytes[k]) begin
      expected_bytes.push_back(step_bytes[k]);
    end
  endtask

  initial begin
    dir_row_t   row;
    logic [7:0] typed_vals[3];
    logic [7:0] seg[$];
    logic       fin;
    int         sent;
    int         kind;

    rst_n = 1'b0;
    push = 1'b0;
    in_byte = 8'h00;
    in_last = 1'b0;
    esc_state = ESC_NONE;
    first_digit = 8'h00;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      send_item(row.code, row.fin, pick_gap());
      decode_byte(row.code, row.fin);
      if (row.typed) begin
        typed_vals[0] = row.e0;
        typed_vals[1] = row.e1;
        typed_vals[2] = row.e2;
        for (int k = 0; k < row.n; k++) begin
          expected_bytes.push_back('{data: typed_vals[k],
                                     fin: (k == row.n - 1) ? row.efin : 1'b0});
        end
      end else begin
        queue_step_bytes();
      end
    end

    // Half the segments are well-formed escapes with random digits; the rest are broken or plain bytes.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      seg.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: begin
          seg.push_back(PCT_CHAR);
          seg.push_back(digit_char($urandom_range(0, 15)));
          seg.push_back(digit_char($urandom_range(0, 15)));
        end
        5, 6: begin
          seg.push_back(8'($urandom_range(0, 255)));
        end
        7: begin
          seg.push_back(PCT_CHAR);
          seg.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          seg.push_back(PCT_CHAR);
          seg.push_back(digit_char($urandom_range(0, 15)));
          seg.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          seg.push_back(PCT_CHAR);
          seg.push_back(8'(8'h61 + $urandom_range(0, 5)));
          seg.push_back(digit_char($urandom_range(0, 15)));
        end
      endcase
      foreach (seg[k]) begin
        calm = (sent >= CALM_FROM);
        if (sent == HOLD_AT) begin
          long_hold_req = 1'b1;
        end
        fin = ($urandom_range(0, 7) == 0);
        send_item(seg[k], fin, pick_gap());
        decode_byte(seg[k], fin);
        queue_step_bytes();
        sent++;
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    dec_byte_t want;
    if (rst_n && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected item, actual out_byte %02h out_last %0b",
                 $time, out_byte, out_last);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h, actual %02h", $time, want.data, out_byte);
          mismatches++;
        end
        if (out_last !== want.fin) begin
          $display("%0t: out_last expected %0b, actual %0b", $time, want.fin, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_unit.sv
sim/tb_url_percent_decoder_unit.sv
